// File: hdl/s20_pkg.sv
// shared constants, types and helpers for the salsa20/8 core pipeline
package s20_pkg;

   localparam int ROUNDS         = 8;
   localparam int DOUBLE_ROUNDS  = ROUNDS / 2;
   localparam int STEPS_PER_HALF = 4;
   localparam int STAGES         = DOUBLE_ROUNDS * 2 * STEPS_PER_HALF;
   localparam int WORDS          = 16;
   localparam int QUARTERS       = 4;

   typedef logic [31:0] word_type;
   typedef word_type [WORDS-1:0] block_type;
   typedef logic [3:0] widx_type;
   typedef logic [4:0] rot_type;

   // which half round and which quarter-round step a stage performs
   typedef struct packed {
      logic       row;
      logic [1:0] step;
   } stage_sel_type;

   // word positions (a, b, c, d) of each quarter round
   localparam widx_type COL_IDX [QUARTERS][4] = '{
      '{4'd0,  4'd4,  4'd8,  4'd12},
      '{4'd5,  4'd9,  4'd13, 4'd1},
      '{4'd10, 4'd14, 4'd2,  4'd6},
      '{4'd15, 4'd3,  4'd7,  4'd11}
   };

   localparam widx_type ROW_IDX [QUARTERS][4] = '{
      '{4'd0,  4'd1,  4'd2,  4'd3},
      '{4'd5,  4'd6,  4'd7,  4'd4},
      '{4'd10, 4'd11, 4'd8,  4'd9},
      '{4'd15, 4'd12, 4'd13, 4'd14}
   };

   // rotation of each step of a quarter round
   localparam rot_type ROT_AMT [4] = '{5'd7, 5'd9, 5'd13, 5'd18};

   function automatic word_type rotl(word_type v, rot_type s);
      return (v << s) | (v >> (6'd32 - {1'b0, s}));
   endfunction

endpackage

// File: hdl/s20_step.sv
// one pipeline stage: one add-rotate-xor step of all four quarter rounds
module s20_step (
   input  logic                   clock,
   input  logic                   reset,
   input  s20_pkg::stage_sel_type sel,
   input  logic                   valid_i,
   input  s20_pkg::block_type     x_i,
   input  s20_pkg::block_type     orig_i,
   output logic                   valid_o,
   output s20_pkg::block_type     x_o,
   output s20_pkg::block_type     orig_o
);

   logic               valid_ff;
   s20_pkg::block_type x_ff;
   s20_pkg::block_type x_in;
   s20_pkg::block_type orig_ff;

   // step k of (a,b,c,d): pos[k+1] ^= rotl(pos[k] + pos[k-1], rot[k])
   always_comb begin
      s20_pkg::widx_type src_cur;
      s20_pkg::widx_type src_prev;
      s20_pkg::widx_type dst;
      logic [1:0]        prev_pos;
      logic [1:0]        next_pos;
      prev_pos = sel.step - 2'd1;
      next_pos = sel.step + 2'd1;
      x_in     = x_i;
      for (int q = 0; q < s20_pkg::QUARTERS; q++) begin
         if (sel.row) begin
            src_cur  = s20_pkg::ROW_IDX[q][sel.step];
            src_prev = s20_pkg::ROW_IDX[q][prev_pos];
            dst      = s20_pkg::ROW_IDX[q][next_pos];
         end else begin
            src_cur  = s20_pkg::COL_IDX[q][sel.step];
            src_prev = s20_pkg::COL_IDX[q][prev_pos];
            dst      = s20_pkg::COL_IDX[q][next_pos];
         end
         x_in[dst] = x_i[dst] ^ s20_pkg::rotl(x_i[src_cur] + x_i[src_prev],
                                              s20_pkg::ROT_AMT[sel.step]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      orig_ff <= orig_i;
   end

   assign valid_o = valid_ff;
   assign x_o     = x_ff;
   assign orig_o  = orig_ff;

endmodule

// File: hdl/salsa20_8_core.sv
// salsa20/8 core: fully pipelined block permutation with feed-forward add
//
// usage
//   raise start with the sixteen input words on req_in_pair_0..7 (even word
//   in bits 31..0, odd word in bits 63..32); the word is taken at any rising
//   edge where start is high and busy is low. busy is high only during reset
//   and in the cycle after it, so a new block can enter on every clock.
//   each result shows on rsp_out_pair_0..7 for exactly one cycle with
//   rsp_strobe high; the receiver must take it then, there is no stall.
// pipeline
//   a block is taken in by one edge into the first of STAGES stage registers
//   (STAGES = ROUNDS / 2 * 8): one stage per quarter-round step, each holding
//   one 32-bit add, a rotate and an xor across all four quarter rounds, then
//   one register for the final add of the input words. one block per cycle
//   sustained while busy is low; blocks come out in the order they went in.
// reset
//   synchronous, active high; clears all valid bits so every word in flight
//   is dropped and no strobe follows. data registers are not cleared.
module salsa20_8_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_in_pair_0,
   input  logic [63:0] req_in_pair_1,
   input  logic [63:0] req_in_pair_2,
   input  logic [63:0] req_in_pair_3,
   input  logic [63:0] req_in_pair_4,
   input  logic [63:0] req_in_pair_5,
   input  logic [63:0] req_in_pair_6,
   input  logic [63:0] req_in_pair_7,
   output logic        rsp_strobe,
   output logic [63:0] rsp_out_pair_0,
   output logic [63:0] rsp_out_pair_1,
   output logic [63:0] rsp_out_pair_2,
   output logic [63:0] rsp_out_pair_3,
   output logic [63:0] rsp_out_pair_4,
   output logic [63:0] rsp_out_pair_5,
   output logic [63:0] rsp_out_pair_6,
   output logic [63:0] rsp_out_pair_7
);

   localparam int STAGES = s20_pkg::STAGES;

   logic               busy_ff;
   logic               accept;
   s20_pkg::block_type in_block;

   // pipeline chain: index 0 is the input side, index STAGES the last stage
   logic               valid_chain [0:STAGES];
   s20_pkg::block_type x_chain     [0:STAGES];
   s20_pkg::block_type orig_chain  [0:STAGES];

   // output registers
   logic               rsp_strobe_ff;
   s20_pkg::block_type sum_ff;
   s20_pkg::block_type sum_in;

   // busy during reset and right after it
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // unpack the pairs into words, even word in the low half
   assign in_block = {req_in_pair_7, req_in_pair_6, req_in_pair_5, req_in_pair_4,
                      req_in_pair_3, req_in_pair_2, req_in_pair_1, req_in_pair_0};

   assign valid_chain[0] = accept;
   assign x_chain[0]     = in_block;
   assign orig_chain[0]  = in_block;

   // each stage: column half rounds on even half-round numbers, rows on odd
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam s20_pkg::stage_sel_type SEL = '{
         row:  1'((s / s20_pkg::STEPS_PER_HALF) % 2),
         step: 2'(s % s20_pkg::STEPS_PER_HALF)
      };

      s20_step u_step (
         .clock   (clock),
         .reset   (reset),
         .sel     (SEL),
         .valid_i (valid_chain[s]),
         .x_i     (x_chain[s]),
         .orig_i  (orig_chain[s]),
         .valid_o (valid_chain[s+1]),
         .x_o     (x_chain[s+1]),
         .orig_o  (orig_chain[s+1])
      );
   end

   // feed-forward: add the original words back in
   always_comb begin
      for (int w = 0; w < s20_pkg::WORDS; w++) begin
         sum_in[w] = x_chain[STAGES][w] + orig_chain[STAGES][w];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= valid_chain[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_out_pair_0 = sum_ff[1:0];
   assign rsp_out_pair_1 = sum_ff[3:2];
   assign rsp_out_pair_2 = sum_ff[5:4];
   assign rsp_out_pair_3 = sum_ff[7:6];
   assign rsp_out_pair_4 = sum_ff[9:8];
   assign rsp_out_pair_5 = sum_ff[11:10];
   assign rsp_out_pair_6 = sum_ff[13:12];
   assign rsp_out_pair_7 = sum_ff[15:14];

   // every strobe traces back to a word taken exactly the pipeline depth ago
   a_strobe_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(accept, STAGES + 1))
      else $error("result strobe without a matching accepted word");

   // the last stage always hands over to the output register
   a_last_stage_drains: assert property (@(posedge clock) disable iff (reset)
      valid_chain[STAGES] |=> rsp_strobe_ff)
      else $error("word in last stage did not reach the output");

   // once out of reset busy stays low, so the core can take a word on every cycle
   a_never_busy: assert property (@(posedge clock)
      !reset |=> !busy_ff)
      else $error("busy raised outside reset");

endmodule

// File: dv/tb_salsa20_8_core.sv
// self-checking testbench for the salsa20/8 block core: directed rows, then random blocks
module tb_salsa20_8_core;
   timeunit 1ns;
   timeprecision 1ps;

   // eight 64-bit pairs, pair k at bits 64k+63..64k; the same bits read as
   // sixteen 32-bit lanes put lane 2k low and lane 2k+1 high in pair k
   typedef logic [7:0][63:0]  pair_block_type;
   typedef logic [15:0][31:0] lane_set_type;

   // one row of the directed table; result is only used when has_result is set
   typedef struct packed {
      pair_block_type data;
      logic           has_result;
      pair_block_type result;
   } stim_row_type;

   localparam int MIX_ROUNDS   = 8;
   localparam int ROT_B        = 7;
   localparam int ROT_C        = 9;
   localparam int ROT_D        = 13;
   localparam int ROT_A        = 18;
   localparam int PIPE_LATENCY = 33;
   localparam int DRAIN_CYCLES = PIPE_LATENCY + 8;
   localparam int LIMIT_CYCLES = 200000;

   // lane positions (a, b, c, d): four column quarters, then four row quarters
   localparam int QR_POS [8][4] = '{
      '{0, 4, 8, 12}, '{5, 9, 13, 1}, '{10, 14, 2, 6}, '{15, 3, 7, 11},
      '{0, 1, 2, 3},  '{5, 6, 7, 4},  '{10, 11, 8, 9}, '{15, 12, 13, 14}
   };

   localparam int NUM_ROWS = 13;

   // the all-zero block is a fixed point of the rounds, and zero plus zero
   // stays zero, so that row carries its answer; the rest go to the predictor
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{{8{64'h0}}, 1'b1, {8{64'h0}}},
      '{{8{64'hFFFF_FFFF_FFFF_FFFF}}, 1'b0, {8{64'h0}}},
      '{{8{64'h5555_5555_5555_5555}}, 1'b0, {8{64'h0}}},
      '{{8{64'hAAAA_AAAA_AAAA_AAAA}}, 1'b0, {8{64'h0}}},
      '{{8{64'h8000_0000_8000_0000}}, 1'b0, {8{64'h0}}},
      '{{8{64'h0000_0001_0000_0001}}, 1'b0, {8{64'h0}}},
      '{{448'h0, 64'h0000_0000_0000_0001}, 1'b0, {8{64'h0}}},
      '{{64'h8000_0000_0000_0000, 448'h0}, 1'b0, {8{64'h0}}},
      '{{8{64'h0000_0000_FFFF_FFFF}}, 1'b0, {8{64'h0}}},
      '{{8{64'hFFFF_FFFF_0000_0000}}, 1'b0, {8{64'h0}}},
      '{{64'h0000_000F_0000_000E, 64'h0000_000D_0000_000C,
         64'h0000_000B_0000_000A, 64'h0000_0009_0000_0008,
         64'h0000_0007_0000_0006, 64'h0000_0005_0000_0004,
         64'h0000_0003_0000_0002, 64'h0000_0001_0000_0000}, 1'b0, {8{64'h0}}},
      '{{4{64'hFFFF_FFFF_FFFF_FFFF, 64'h0}}, 1'b0, {8{64'h0}}},
      '{{4{64'h0, 64'hFFFF_FFFF_FFFF_FFFF}}, 1'b0, {8{64'h0}}}
   };

   logic           clock;
   logic           reset;
   logic           start;
   logic           busy;
   pair_block_type req_block;
   logic           rsp_strobe;
   wire [7:0][63:0] rsp_block;

   // blocks still owed by the pipeline, oldest first
   pair_block_type blocks_due [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned idle_pct;

   salsa20_8_core DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_in_pair_0  (req_block[0]),
      .req_in_pair_1  (req_block[1]),
      .req_in_pair_2  (req_block[2]),
      .req_in_pair_3  (req_block[3]),
      .req_in_pair_4  (req_block[4]),
      .req_in_pair_5  (req_block[5]),
      .req_in_pair_6  (req_block[6]),
      .req_in_pair_7  (req_block[7]),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_pair_0 (rsp_block[0]),
      .rsp_out_pair_1 (rsp_block[1]),
      .rsp_out_pair_2 (rsp_block[2]),
      .rsp_out_pair_3 (rsp_block[3]),
      .rsp_out_pair_4 (rsp_block[4]),
      .rsp_out_pair_5 (rsp_block[5]),
      .rsp_out_pair_6 (rsp_block[6]),
      .rsp_out_pair_7 (rsp_block[7])
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] rotl32(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   // salsa20/8: four double rounds on a working copy, then feed-forward add
   function automatic pair_block_type salsa8_block(pair_block_type in_block);
      lane_set_type orig;
      lane_set_type x;
      int a, b, c, d;
      orig = in_block;
      x    = orig;
      for (int dr = 0; dr < MIX_ROUNDS / 2; dr++) begin
         for (int q = 0; q < 8; q++) begin
            a = QR_POS[q][0];
            b = QR_POS[q][1];
            c = QR_POS[q][2];
            d = QR_POS[q][3];
            x[b] = x[b] ^ rotl32(x[a] + x[d], ROT_B);
            x[c] = x[c] ^ rotl32(x[b] + x[a], ROT_C);
            x[d] = x[d] ^ rotl32(x[c] + x[b], ROT_D);
            x[a] = x[a] ^ rotl32(x[d] + x[c], ROT_A);
         end
      end
      for (int i = 0; i < 16; i++) begin
         x[i] = x[i] + orig[i];
      end
      return x;
   endfunction

   // mostly uniform lanes, with a share of all-zero, all-one,
   // single-bit and single-hole lanes to hit the carry chains hard
   function automatic pair_block_type random_block();
      lane_set_type lanes;
      for (int i = 0; i < 16; i++) begin
         case ($urandom_range(0, 9))
            0: lanes[i] = 32'h0;
            1: lanes[i] = 32'hFFFF_FFFF;
            2: lanes[i] = 32'h1 << $urandom_range(0, 31);
            3: lanes[i] = ~(32'h1 << $urandom_range(0, 31));
            default: lanes[i] = $urandom;
         endcase
      end
      return lanes;
   endfunction

   // present one word and hold it until the core takes it; each cycle
   // before it idles with the phase's odds, carrying junk data with start low
   task automatic send_block(pair_block_type data, logic has_result,
                             pair_block_type result);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start     <= 1'b0;
         req_block <= random_block();
      end
      @(negedge clock);
      start     <= 1'b1;
      req_block <= data;
      // busy is read before the edge's own updates land
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      if (has_result) begin
         blocks_due.push_back(result);
      end else begin
         blocks_due.push_back(salsa8_block(data));
      end
   endtask

   // result check: every strobe must match the oldest block owed, pair by pair
   always @(posedge clock) begin
      pair_block_type due;
      if (!reset && rsp_strobe) begin
         if (blocks_due.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: result word with none due, expected nothing got %h",
                     $time, rsp_block);
         end else begin
            due = blocks_due.pop_front();
            for (int k = 0; k < 8; k++) begin
               if (rsp_block[k] !== due[k]) begin
                  mismatch_count++;
                  $display("%0t ns: out_pair_%0d expected %h got %h",
                           $time, k, due[k], rsp_block[k]);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("tb_salsa20_8_core: errors");
      $finish;
   end

   // stimulus: directed rows, then three random phases with the sender
   // idling rarely, often, and not at all
   initial begin
      int unsigned phase_pct [3];
      int unsigned phase_len [3];
      phase_pct = '{8, 84, 0};
      phase_len = '{520, 520, 510};
      reset     = 1'b1;
      start     = 1'b0;
      req_block = '0;
      idle_pct  = phase_pct[0];
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_ROWS; r++) begin
         send_block(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].has_result,
                    DIRECTED_ROWS[r].result);
      end

      for (int p = 0; p < 3; p++) begin
         idle_pct = phase_pct[p];
         for (int n = 0; n < phase_len[p]; n++) begin
            send_block(random_block(), 1'b0, '0);
         end
      end

      @(negedge clock);
      start <= 1'b0;

      // drain the pipeline, then watch a little longer for stray strobes
      while (blocks_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb_salsa20_8_core: clean");
      end else begin
         $display("tb_salsa20_8_core: errors");
      end
      $finish;
   end

endmodule
